// File: design/cgs_pkg.sv
// Shared constants, types and helpers for the clamp grasp sequencer.
package cgs_pkg;

    localparam int WINDOW_DEPTH = 10;
    localparam int SAMPLE_W     = 16;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = SAMPLE_W + COUNT_W;

    localparam int SCALE_W      = 8;
    localparam int DRIVE_W      = SCALE_W + 1;
    localparam int CODE_W       = 16;
    localparam int FORCE_W      = 16;
    localparam int PHASE_W      = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_THRES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_THRES   = 2'd2;

    localparam logic [SCALE_W-1:0]         DRIVE_SCALE_RST   = 8'd128;
    localparam logic [SAMPLE_W-1:0]        STRETCH_THRES_RST = 16'd1152;
    localparam logic signed [FORCE_W-1:0]  FORCE_THRES_RST   = 16'sd900;
    localparam logic signed [CODE_W-1:0]   CMD_RUN           = 16'sd7;

    typedef enum logic [5:0] {
        PH_LOWER = 6'b000001,
        PH_OPEN  = 6'b000010,
        PH_WAIT  = 6'b000100,
        PH_CLOSE = 6'b001000,
        PH_RAISE = 6'b010000,
        PH_DONE  = 6'b100000
    } phase_t;

    localparam logic [PHASE_W-1:0] PHASE_LOWER_CODE = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_OPEN_CODE  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_WAIT_CODE  = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_CLOSE_CODE = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_RAISE_CODE = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_DONE_CODE  = 3'd5;

    // A new stretch sample entering the window.
    typedef struct packed {
        logic                push;
        logic [SAMPLE_W-1:0] sample;
    } window_req_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_LOWER: code = PHASE_LOWER_CODE;
            PH_OPEN:  code = PHASE_OPEN_CODE;
            PH_WAIT:  code = PHASE_WAIT_CODE;
            PH_CLOSE: code = PHASE_CLOSE_CODE;
            PH_RAISE: code = PHASE_RAISE_CODE;
            PH_DONE:  code = PHASE_DONE_CODE;
            default:  code = PHASE_LOWER_CODE;
        endcase
        return code;
    endfunction

endpackage

// File: design/cgs_window.sv
// Running-sum stretch window and the plate engagement comparison.
module cgs_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cgs_pkg::window_req_t          req,
    input  logic [cgs_pkg::SAMPLE_W-1:0]  threshold,
    output logic                          engaged
);
    import cgs_pkg::*;

    logic [SAMPLE_W-1:0] store_reg [WINDOW_DEPTH];
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                full;
    logic [SAMPLE_W-1:0] oldest;
    logic [SUM_W-1:0]    limit;

    assign full   = (count_reg == COUNT_W'(WINDOW_DEPTH));
    assign oldest = full ? store_reg[slot_reg] : '0;

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        if (req.push) begin
            // When the window is full the oldest sample leaves before the new one enters.
            sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(req.sample);
            if (!full) begin
                count_next = count_reg + COUNT_W'(1);
            end
            slot_next = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
        end
    end

    // Mean above threshold, tested without a division.
    assign limit   = SUM_W'(threshold) * SUM_W'(count_next);
    assign engaged = (sum_next > limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            slot_reg  <= '0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.push) begin
            store_reg[slot_reg] <= req.sample;
        end
    end

endmodule

// File: design/clamp_grasp_sequencer_core.sv
// Top level of the clamp grasp sequencer: phase cascade, drives and handshakes.
// A request's result is presented in the cycle after it is accepted.
// Throughput: one request per cycle; the result register holds the sequencer
// state, so a new request is taken whenever that register is empty or drained.
// Reset (synchronous, aresetn low): phase lowering, drives zero, flags clear,
// stretch window empty, registers at their defaults; no clearing pass.
module clamp_grasp_sequencer_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [cgs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cgs_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [cgs_pkg::CODE_W-1:0]    s_controller_code,
    input  logic                                 s_limit_up,
    input  logic                                 s_limit_down,
    input  logic                                 s_limit_open,
    input  logic                                 s_limit_close,
    input  logic signed [cgs_pkg::FORCE_W-1:0]   s_force_reading,
    input  logic [cgs_pkg::SAMPLE_W-1:0]         s_stretch_sample,
    input  logic                                 s_stretch_valid,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [cgs_pkg::DRIVE_W-1:0]   m_lift_drive,
    output logic signed [cgs_pkg::DRIVE_W-1:0]   m_grip_drive,
    output logic                                 m_plate_ok,
    output logic                                 m_grasp_ok,
    output logic                                 m_pick_done,
    output logic [cgs_pkg::PHASE_W-1:0]          m_phase
);
    import cgs_pkg::*;

    logic [SCALE_W-1:0]        drive_scale_reg;
    logic [SAMPLE_W-1:0]       stretch_thres_reg;
    logic signed [FORCE_W-1:0] force_thres_reg;

    phase_t                    phase_reg, phase_next;
    logic signed [DRIVE_W-1:0] lift_drive_reg, lift_drive_next;
    logic signed [DRIVE_W-1:0] grip_drive_reg, grip_drive_next;
    logic                      plate_ok_reg, plate_ok_next;
    logic                      grasp_ok_reg, grasp_ok_next;
    logic                      finished_reg, finished_next;
    logic                      m_valid_reg;

    logic                      accept;
    logic                      engaged;
    logic signed [DRIVE_W-1:0] drive_pos, drive_neg;
    window_req_t               win_req;

    // The result register doubles as the sequencer state, so a request is
    // only taken once the previous result has gone.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign win_req.push   = accept && s_stretch_valid;
    assign win_req.sample = s_stretch_sample;

    cgs_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (win_req),
        .threshold (stretch_thres_reg),
        .engaged   (engaged)
    );

    assign drive_pos = $signed({1'b0, drive_scale_reg});
    assign drive_neg = -drive_pos;

    // Phase tests run in order, so one request may pass through several phases.
    always_comb begin
        phase_next      = phase_reg;
        lift_drive_next = lift_drive_reg;
        grip_drive_next = grip_drive_reg;
        plate_ok_next   = plate_ok_reg;
        grasp_ok_next   = grasp_ok_reg;
        finished_next   = 1'b0;
        if (s_controller_code == CMD_RUN) begin
            if (phase_next == PH_LOWER) begin
                if (!s_limit_down) begin
                    lift_drive_next = drive_pos;
                end else begin
                    lift_drive_next = '0;
                    phase_next      = PH_OPEN;
                end
            end
            if (phase_next == PH_OPEN) begin
                if (!s_limit_open) begin
                    grip_drive_next = drive_pos;
                end else begin
                    grip_drive_next = '0;
                    phase_next      = PH_WAIT;
                end
            end
            if (phase_next == PH_WAIT) begin
                plate_ok_next = engaged;
                if (engaged) begin
                    phase_next = PH_CLOSE;
                end
            end
            if (phase_next == PH_CLOSE) begin
                plate_ok_next   = engaged;
                grip_drive_next = s_limit_close ? '0 : drive_neg;
                if (engaged && (s_force_reading > force_thres_reg || s_limit_close)) begin
                    grasp_ok_next = 1'b1;
                    phase_next    = PH_RAISE;
                end else if (!engaged) begin
                    grasp_ok_next = 1'b0;
                    phase_next    = PH_OPEN;
                end
            end
            if (phase_next == PH_RAISE) begin
                if (!s_limit_up) begin
                    lift_drive_next = drive_neg;
                end else begin
                    lift_drive_next = '0;
                    phase_next      = PH_DONE;
                end
            end
            if (phase_next == PH_DONE) begin
                finished_next = 1'b1;
            end
        end else begin
            lift_drive_next = '0;
            grip_drive_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_scale_reg   <= DRIVE_SCALE_RST;
            stretch_thres_reg <= STRETCH_THRES_RST;
            force_thres_reg   <= FORCE_THRES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DRIVE_SCALE:   drive_scale_reg   <= cfg_wr_data[SCALE_W-1:0];
                CFG_STRETCH_THRES: stretch_thres_reg <= cfg_wr_data[SAMPLE_W-1:0];
                CFG_FORCE_THRES:   force_thres_reg   <= $signed(cfg_wr_data[FORCE_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LOWER;
            lift_drive_reg <= '0;
            grip_drive_reg <= '0;
            plate_ok_reg   <= 1'b0;
            grasp_ok_reg   <= 1'b0;
            finished_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                lift_drive_reg <= lift_drive_next;
                grip_drive_reg <= grip_drive_next;
                plate_ok_reg   <= plate_ok_next;
                grasp_ok_reg   <= grasp_ok_next;
                finished_reg   <= finished_next;
            end
            m_valid_reg <= accept || (m_valid_reg && !m_ready);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_lift_drive = lift_drive_reg;
    assign m_grip_drive = grip_drive_reg;
    assign m_plate_ok   = plate_ok_reg;
    assign m_grasp_ok   = grasp_ok_reg;
    assign m_pick_done  = finished_reg;
    assign m_phase      = phase_code(phase_reg);

    // The done flag is only ever raised in the done phase.
    a_finished_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_pick_done |-> (m_phase == PHASE_DONE_CODE))
        else $error("done flag raised outside the done phase");

    // Any command other than run stops both drives.
    a_stop_on_other_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_controller_code != CMD_RUN) |=>
        (m_lift_drive == '0 && m_grip_drive == '0 && !m_pick_done))
        else $error("drives not stopped for a non-run command");

    // A result still waiting must block the next request.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("request taken while a result is stalled");

    // A completed grasp means the plate was engaged at that time.
    a_grasp_needs_plate: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_CLOSE && phase_next == PH_RAISE) |=> m_plate_ok)
        else $error("grasp completed without plate engagement");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the clamp grasp sequencer: directed and random pick sequences.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cgs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;

    typedef struct {
        logic signed [CODE_W-1:0]  code;
        logic                      lim_up;
        logic                      lim_down;
        logic                      lim_open;
        logic                      lim_close;
        logic signed [FORCE_W-1:0] force_val;
        logic [SAMPLE_W-1:0]       stretch;
        logic                      fresh;
    } tick_t;

    typedef struct {
        logic signed [DRIVE_W-1:0] lift;
        logic signed [DRIVE_W-1:0] grip;
        logic                      plate_ok;
        logic                      grasp_ok;
        logic                      finished;
        logic [PHASE_W-1:0]        phase;
    } outputs_t;

    logic                        aclk              = 1'b0;
    logic                        aresetn           = 1'b0;
    logic                        cfg_wr_en         = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index         = CFG_DRIVE_SCALE;
    logic [CFG_DATA_W-1:0]       cfg_wr_data       = '0;
    logic                        s_valid           = 1'b0;
    logic                        s_ready;
    logic signed [CODE_W-1:0]    s_controller_code = '0;
    logic                        s_limit_up        = 1'b0;
    logic                        s_limit_down      = 1'b0;
    logic                        s_limit_open      = 1'b0;
    logic                        s_limit_close     = 1'b0;
    logic signed [FORCE_W-1:0]   s_force_reading   = '0;
    logic [SAMPLE_W-1:0]         s_stretch_sample  = '0;
    logic                        s_stretch_valid   = 1'b0;
    logic                        m_valid;
    logic                        m_ready           = 1'b0;
    logic signed [DRIVE_W-1:0]   m_lift_drive;
    logic signed [DRIVE_W-1:0]   m_grip_drive;
    logic                        m_plate_ok;
    logic                        m_grasp_ok;
    logic                        m_pick_done;
    logic [PHASE_W-1:0]          m_phase;

    // Mirror of the sequencer state and its settings.
    logic [PHASE_W-1:0]          seq_phase;
    logic signed [DRIVE_W-1:0]   lift_hold;
    logic signed [DRIVE_W-1:0]   grip_hold;
    logic                        plate_hold;
    logic                        grasp_hold;
    logic [SAMPLE_W-1:0]         window_mem [WINDOW_DEPTH];
    logic [SUM_W-1:0]            window_sum;
    logic [COUNT_W-1:0]          window_fill;
    int                          window_slot;
    logic [SCALE_W-1:0]          drive_scale;
    logic [SAMPLE_W-1:0]         plate_thr;
    logic signed [FORCE_W-1:0]   grasp_thr;

    outputs_t predicted_outputs[$];
    int       mismatches    = 0;
    int       cycles_run    = 0;
    bit       tx_pauses     = 1'b1;
    bit       rx_pauses     = 1'b1;
    bit       hold_request  = 1'b0;

    clamp_grasp_sequencer_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_controller_code (s_controller_code),
        .s_limit_up        (s_limit_up),
        .s_limit_down      (s_limit_down),
        .s_limit_open      (s_limit_open),
        .s_limit_close     (s_limit_close),
        .s_force_reading   (s_force_reading),
        .s_stretch_sample  (s_stretch_sample),
        .s_stretch_valid   (s_stretch_valid),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_lift_drive      (m_lift_drive),
        .m_grip_drive      (m_grip_drive),
        .m_plate_ok        (m_plate_ok),
        .m_grasp_ok        (m_grasp_ok),
        .m_pick_done       (m_pick_done),
        .m_phase           (m_phase)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles_run++;
        if (cycles_run == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic reset_predictor();
        seq_phase   = PHASE_LOWER_CODE;
        lift_hold   = '0;
        grip_hold   = '0;
        plate_hold  = 1'b0;
        grasp_hold  = 1'b0;
        window_sum  = '0;
        window_fill = '0;
        window_slot = 0;
        drive_scale = DRIVE_SCALE_RST;
        plate_thr   = STRETCH_THRES_RST;
        grasp_thr   = FORCE_THRES_RST;
        foreach (window_mem[i]) window_mem[i] = '0;
    endtask

    // The mean test without a division: sum against threshold times fill.
    function automatic logic window_above_threshold();
        return 32'(window_sum) > 32'(plate_thr) * 32'(window_fill);
    endfunction

    task automatic predict_tick(input tick_t t, output outputs_t o);
        logic signed [DRIVE_W-1:0] mag;
        mag = $signed({1'b0, drive_scale});
        o.finished = 1'b0;
        if (t.fresh) begin
            if (window_fill == COUNT_W'(WINDOW_DEPTH))
                window_sum = window_sum - SUM_W'(window_mem[window_slot]);
            else
                window_fill = window_fill + COUNT_W'(1);
            window_mem[window_slot] = t.stretch;
            window_sum = window_sum + SUM_W'(t.stretch);
            window_slot = (window_slot == WINDOW_DEPTH - 1) ? 0 : window_slot + 1;
        end
        if (t.code == CMD_RUN) begin
            // The phase tests run in order, so one tick may pass several phases.
            if (seq_phase == PHASE_LOWER_CODE) begin
                if (!t.lim_down) begin
                    lift_hold = mag;
                end else begin
                    lift_hold = '0;
                    seq_phase = PHASE_OPEN_CODE;
                end
            end
            if (seq_phase == PHASE_OPEN_CODE) begin
                if (!t.lim_open) begin
                    grip_hold = mag;
                end else begin
                    grip_hold = '0;
                    seq_phase = PHASE_WAIT_CODE;
                end
            end
            if (seq_phase == PHASE_WAIT_CODE) begin
                plate_hold = window_above_threshold();
                if (plate_hold)
                    seq_phase = PHASE_CLOSE_CODE;
            end
            if (seq_phase == PHASE_CLOSE_CODE) begin
                plate_hold = window_above_threshold();
                grip_hold  = t.lim_close ? '0 : -mag;
                if (plate_hold && (t.force_val > grasp_thr || t.lim_close)) begin
                    grasp_hold = 1'b1;
                    seq_phase  = PHASE_RAISE_CODE;
                end else if (!plate_hold) begin
                    grasp_hold = 1'b0;
                    seq_phase  = PHASE_OPEN_CODE;
                end
            end
            if (seq_phase == PHASE_RAISE_CODE) begin
                if (!t.lim_up) begin
                    lift_hold = -mag;
                end else begin
                    lift_hold = '0;
                    seq_phase = PHASE_DONE_CODE;
                end
            end
            if (seq_phase == PHASE_DONE_CODE)
                o.finished = 1'b1;
        end else begin
            lift_hold = '0;
            grip_hold = '0;
        end
        o.lift     = lift_hold;
        o.grip     = grip_hold;
        o.plate_ok = plate_hold;
        o.grasp_ok = grasp_hold;
        o.phase    = seq_phase;
    endtask

    // Offers one request, records its prediction on acceptance, then maybe pauses.
    task automatic send_tick(input tick_t t);
        outputs_t o;
        s_valid           <= 1'b1;
        s_controller_code <= t.code;
        s_limit_up        <= t.lim_up;
        s_limit_down      <= t.lim_down;
        s_limit_open      <= t.lim_open;
        s_limit_close     <= t.lim_close;
        s_force_reading   <= t.force_val;
        s_stretch_sample  <= t.stretch;
        s_stretch_valid   <= t.fresh;
        do @(posedge aclk); while (!s_ready);
        predict_tick(t, o);
        predicted_outputs.insert(predicted_outputs.size(), o);
        if (tx_pauses && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    function automatic tick_t make_tick(input logic signed [CODE_W-1:0] code,
                                        input logic up, input logic down,
                                        input logic opn, input logic cls,
                                        input logic signed [FORCE_W-1:0] frc,
                                        input logic [SAMPLE_W-1:0] stretch,
                                        input logic fresh);
        tick_t t;
        t.code      = code;
        t.lim_up    = up;
        t.lim_down  = down;
        t.lim_open  = opn;
        t.lim_close = cls;
        t.force_val = frc;
        t.stretch   = stretch;
        t.fresh     = fresh;
        return t;
    endfunction

    function automatic tick_t random_tick(input int run_pct, input int close_pct,
                                          input int strong_pct);
        tick_t t;
        int    roll;
        int    lo;
        int    near;
        roll = $urandom_range(0, 99);
        if (roll < run_pct)
            t.code = CMD_RUN;
        else if (roll < run_pct + 4)
            t.code = $urandom_range(0, 1) ? CMD_RUN + 16'sd1 : CMD_RUN - 16'sd1;
        else
            t.code = CODE_W'($urandom);
        t.lim_up    = 1'($urandom_range(0, 1));
        t.lim_down  = 1'($urandom_range(0, 1));
        t.lim_open  = 1'($urandom_range(0, 1));
        t.lim_close = $urandom_range(0, 99) < close_pct;
        lo = int'(grasp_thr);
        if (lo < 32767 && $urandom_range(0, 99) < strong_pct)
            t.force_val = FORCE_W'(lo + 1 + int'($urandom_range(0, 32766 - lo)));
        else
            t.force_val = FORCE_W'(int'($urandom_range(0, lo + 32768)) - 32768);
        t.fresh = $urandom_range(0, 99) < 60;
        case ($urandom_range(0, 3))
            0: t.stretch = SAMPLE_W'($urandom);
            1: t.stretch = $urandom_range(0, 1) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}};
            default: begin
                // Samples close to the threshold make the plate judgement flicker.
                near = int'(plate_thr) + int'($urandom_range(0, 512)) - 256;
                if (near < 0)
                    t.stretch = '0;
                else if (near > 65535)
                    t.stretch = {SAMPLE_W{1'b1}};
                else
                    t.stretch = SAMPLE_W'(near);
            end
        endcase
        return t;
    endfunction

    task automatic run_random(input int count, input int run_pct, input int close_pct,
                              input int strong_pct, input bit vary_pauses);
        for (int i = 0; i < count; i++) begin
            if (vary_pauses && $urandom_range(0, 39) == 0) begin
                tx_pauses = 1'($urandom_range(0, 1));
                rx_pauses = 1'($urandom_range(0, 1));
            end
            send_tick(random_tick(run_pct, close_pct, strong_pct));
        end
    endtask

    // Settings change only once every outstanding result has come back.
    task automatic set_registers(input logic [SCALE_W-1:0] scale,
                                 input logic [SAMPLE_W-1:0] pthr,
                                 input logic signed [FORCE_W-1:0] fthr);
        s_valid <= 1'b0;
        do @(posedge aclk); while (predicted_outputs.size() != 0);
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_DRIVE_SCALE;
        cfg_wr_data <= CFG_DATA_W'(scale);
        @(posedge aclk);
        drive_scale = scale;
        cfg_index   <= CFG_STRETCH_THRES;
        cfg_wr_data <= pthr;
        @(posedge aclk);
        plate_thr = pthr;
        cfg_index   <= CFG_FORCE_THRES;
        cfg_wr_data <= fthr;
        @(posedge aclk);
        grasp_thr = fthr;
        cfg_wr_en <= 1'b0;
    endtask

    // Lowering, opening, a weak grasp, a full window of zeros and a lost plate.
    task automatic test_early_phases();
        logic signed [CODE_W-1:0] others [10];
        others = '{16'sh8000, 16'sh7FFF, CMD_RUN - 16'sd1, CMD_RUN + 16'sd1, 16'sh0000,
                   -CMD_RUN, 16'sh5555, 16'shAAAA, CMD_RUN | 16'sh0100, -16'sd1};
        send_tick(make_tick(CMD_RUN, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh7FFF, 16'hFFFF, 1'b1));
        send_tick(make_tick(CMD_RUN, 1'b0, 1'b1, 1'b0, 1'b0, 16'sh0000, 16'h0000, 1'b0));
        // A force equal to the threshold does not count as a grasp.
        send_tick(make_tick(CMD_RUN, 1'b0, 1'b1, 1'b1, 1'b0, FORCE_THRES_RST, 16'h0, 1'b0));
        send_tick(make_tick(CMD_RUN, 1'b1, 1'b1, 1'b1, 1'b0, 16'sh8000, 16'h0000, 1'b0));
        // Ten zero samples fill the window and push the large sample out.
        for (int i = 0; i < 10; i++)
            send_tick(make_tick(others[i], i[0], i[0], i[0], i[0],
                                i[0] ? 16'sh7FFF : 16'sh8000, 16'h0000, 1'b1));
        send_tick(make_tick(CMD_RUN, 1'b0, 1'b0, 1'b0, 1'b1, 16'sh7FFF, 16'h0000, 1'b0));
        send_tick(make_tick(CMD_RUN, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh0000, 16'h0000, 1'b0));
    endtask

    // Long random stretches in the early phases; a grasp is kept rare.
    task automatic test_sequence_search();
        set_registers(8'hFF, SAMPLE_W'(16000 + $urandom_range(0, 8000)), 16'sh7FFF);
        run_random(150, 85, 2, 0, 1'b1);
        set_registers(8'h00, 16'hFFFF, FORCE_W'($urandom));
        run_random(100, 85, 5, 5, 1'b1);
        set_registers(SCALE_W'($urandom), SAMPLE_W'($urandom_range(200, 40000)),
                      FORCE_W'($urandom));
        run_random(200, 80, 2, 2, 1'b1);
    endtask

    // A successful grasp, the raise and the held done phase.
    task automatic test_grasp_and_raise();
        set_registers(8'hFF, 16'h0000, 16'sh0000);
        send_tick(make_tick(CMD_RUN, 1'b0, 1'b1, 1'b1, 1'b0, 16'sd1, 16'h0001, 1'b1));
        send_tick(make_tick(CMD_RUN ^ 16'sh0004, 1'b0, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 1'b0));
        send_tick(make_tick(CMD_RUN, 1'b0, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0000, 1'b0));
        send_tick(make_tick(CMD_RUN, 1'b1, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0000, 1'b0));
        send_tick(make_tick(CMD_RUN, 1'b1, 1'b1, 1'b1, 1'b1, 16'sh8000, 16'hFFFF, 1'b1));
        send_tick(make_tick(16'sh8000, 1'b1, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 16'h0000, 1'b0));
    endtask

    task automatic test_done_random();
        set_registers(8'h00, 16'h0000, 16'sh8000);
        run_random(100, 60, 10, 50, 1'b1);
        set_registers(SCALE_W'($urandom), SAMPLE_W'($urandom), FORCE_W'($urandom));
        run_random(150, 70, 10, 10, 1'b1);
    endtask

    // The result side holds off while requests keep coming, so the block stalls.
    task automatic test_backpressure();
        tx_pauses    = 1'b0;
        hold_request = 1'b1;
        run_random(30, 70, 10, 10, 1'b0);
    endtask

    task automatic test_final_stretch();
        tx_pauses = 1'b0;
        rx_pauses = 1'b0;
        run_random(60, 80, 5, 5, 1'b0);
    endtask

    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (rx_pauses && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        outputs_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_outputs.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
            end else begin
                want = predicted_outputs.pop_front();
                if (m_lift_drive !== want.lift) begin
                    $error("lift_drive: expected %0d, got %0d", want.lift, m_lift_drive);
                    mismatches++;
                end
                if (m_grip_drive !== want.grip) begin
                    $error("grip_drive: expected %0d, got %0d", want.grip, m_grip_drive);
                    mismatches++;
                end
                if (m_plate_ok !== want.plate_ok) begin
                    $error("plate_ok: expected %0d, got %0d", want.plate_ok, m_plate_ok);
                    mismatches++;
                end
                if (m_grasp_ok !== want.grasp_ok) begin
                    $error("grasp_ok: expected %0d, got %0d", want.grasp_ok, m_grasp_ok);
                    mismatches++;
                end
                if (m_pick_done !== want.finished) begin
                    $error("pick_done: expected %0d, got %0d",
                           want.finished, m_pick_done);
                    mismatches++;
                end
                if (m_phase !== want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, m_phase);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        reset_predictor();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_early_phases();
        test_sequence_search();
        test_grasp_and_raise();
        test_done_random();
        test_backpressure();
        test_final_stretch();
        s_valid <= 1'b0;
        do @(posedge aclk); while (predicted_outputs.size() != 0);
        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
design/cgs_pkg.sv
design/cgs_window.sv
design/clamp_grasp_sequencer_core.sv
tb/tb.sv
